// ===== rtl/core/ssts_pkg.sv =====
// Shared types and codes for the sorted store with two-sum search.
// No dependencies; used by every module of the block.
`default_nettype none

package ssts_pkg;

  localparam int STORE_DEPTH_DEF = 256;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_FOUND    = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] operand_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] index_low;
    logic [7:0] index_high;
  } rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               clear;
    logic               insert;
    logic               load;
    logic               step_lo;
    logic               step_hi;
    logic signed [31:0] value;
  } cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic               valid;
    logic               gt;
    logic signed [31:0] val;
    logic signed [31:0] l;
    logic signed [31:0] h;
    logic               hv;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRESHIFT,
    ST_SEARCH,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssts_cell.sv =====
// One cell of the sorted chain: a stored entry plus its two search lines.
// Depends on ssts_pkg.
`default_nettype none

module ssts_cell (
  input  logic           clk,
  input  logic           rst,
  input  ssts_pkg::cmd_t  cmd,
  input  ssts_pkg::link_t dn,   // neighbor at index - 1
  input  ssts_pkg::link_t up,   // neighbor at index + 1
  output ssts_pkg::link_t self
);

  logic               valid;
  logic signed [31:0] val;
  logic signed [31:0] l;
  logic signed [31:0] h;
  logic               hv;
  logic               gt;

  assign gt = valid && (val > cmd.value);

  assign self.valid = valid;
  assign self.gt    = gt;
  assign self.val   = val;
  assign self.l     = l;
  assign self.h     = h;
  assign self.hv    = hv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.insert && dn.valid) begin
      valid <= 1'b1;
    end
  end

  // Insert: entries above the new value move up one cell; the first cell
  // holding a larger value (or the first empty cell) takes the new value.
  always_ff @(posedge clk) begin
    if (cmd.insert && dn.valid) begin
      if (dn.gt) begin
        val <= dn.val;
      end else if (gt || !valid) begin
        val <= cmd.value;
      end
    end
  end

  // Low line walks toward index 0, high line toward the top cell.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l <= val;
    end else if (cmd.step_lo) begin
      l <= up.l;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h  <= val;
      hv <= valid;
    end else if (cmd.step_hi) begin
      h  <= dn.h;
      hv <= dn.hv;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssts_ctrl.sv =====
// Sequencer: decodes items, drives the cell chain, runs the pointer search
// and holds the result register. Depends on ssts_pkg.
`default_nettype none

module ssts_ctrl #(
  parameter int STORE_DEPTH = ssts_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ssts_pkg::req_t     req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ssts_pkg::rsp_t     rsp,
  output ssts_pkg::cmd_t     cmd,
  input  logic signed [31:0] lo_val,   // low line at cell 0
  input  logic signed [31:0] hi_val,   // high line at the top cell
  input  logic               hi_hv
);

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  ssts_pkg::state_t state, state_next;

  logic [CW-1:0]      count;
  logic [IW-1:0]      lo;
  logic [IW-1:0]      hi;
  logic signed [31:0] target;
  ssts_pkg::rsp_t     pend;

  logic               accept;
  logic               slot_free;
  logic               finish;
  ssts_pkg::rsp_t     fin_rsp;
  logic               full;
  logic               few;
  logic signed [32:0] sum;
  logic signed [32:0] tgt_ext;
  logic [IW+7:0]      lo_ext;
  logic [IW+7:0]      hi_ext;

  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign full      = (count == CW'(STORE_DEPTH));
  assign few       = (count < CW'(2));
  assign sum       = {lo_val[31], lo_val} + {hi_val[31], hi_val};
  assign tgt_ext   = {target[31], target};
  assign lo_ext    = {8'd0, lo};
  assign hi_ext    = {8'd0, hi};

  // Outputs of the sequencer
  always_comb begin
    req_ready   = (state == ssts_pkg::ST_IDLE);
    cmd         = '0;
    cmd.value   = req.operand_value;
    finish      = 1'b0;
    fin_rsp     = '0;
    unique case (state)
      ssts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.action)
            ssts_pkg::ACT_CLEAR: begin
              cmd.clear      = 1'b1;
              finish         = 1'b1;
              fin_rsp.status = ssts_pkg::STATUS_DONE;
            end
            ssts_pkg::ACT_INSERT: begin
              finish = 1'b1;
              if (full) begin
                fin_rsp.status = ssts_pkg::STATUS_FULL;
              end else begin
                cmd.insert     = 1'b1;
                fin_rsp.status = ssts_pkg::STATUS_DONE;
              end
            end
            ssts_pkg::ACT_QUERY: begin
              if (few) begin
                finish         = 1'b1;
                fin_rsp.status = ssts_pkg::STATUS_NOTFOUND;
              end else begin
                cmd.load = 1'b1;
              end
            end
            default: begin
              finish         = 1'b1;
              fin_rsp.status = ssts_pkg::STATUS_DONE;
            end
          endcase
        end
      end
      ssts_pkg::ST_PRESHIFT: begin
        // bring entry count-1 up to the top cell
        if (!hi_hv) begin
          cmd.step_hi = 1'b1;
        end
      end
      ssts_pkg::ST_SEARCH: begin
        if (lo >= hi) begin
          finish         = 1'b1;
          fin_rsp.status = ssts_pkg::STATUS_NOTFOUND;
        end else if (sum > tgt_ext) begin
          cmd.step_hi = 1'b1;
        end else if (sum < tgt_ext) begin
          cmd.step_lo = 1'b1;
        end else begin
          finish             = 1'b1;
          fin_rsp.status     = ssts_pkg::STATUS_FOUND;
          fin_rsp.index_low  = lo_ext[7:0];
          fin_rsp.index_high = hi_ext[7:0];
        end
      end
      ssts_pkg::ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ssts_pkg::ST_IDLE: begin
        if (cmd.load) begin
          state_next = ssts_pkg::ST_PRESHIFT;
        end else if (finish && !slot_free) begin
          state_next = ssts_pkg::ST_HOLD;
        end
      end
      ssts_pkg::ST_PRESHIFT: begin
        if (hi_hv) begin
          state_next = ssts_pkg::ST_SEARCH;
        end
      end
      ssts_pkg::ST_SEARCH: begin
        if (finish) begin
          state_next = slot_free ? ssts_pkg::ST_IDLE : ssts_pkg::ST_HOLD;
        end
      end
      ssts_pkg::ST_HOLD: begin
        if (slot_free) begin
          state_next = ssts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ssts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo     <= '0;
      hi     <= IW'(count - CW'(1));
      target <= req.operand_value;
    end else if (state == ssts_pkg::ST_SEARCH) begin
      if (cmd.step_lo) begin
        lo <= lo + IW'(1);
      end
      if (cmd.step_hi) begin
        hi <= hi - IW'(1);
      end
    end
  end

  // Result register, with one pending slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((finish || state == ssts_pkg::ST_HOLD) && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ssts_pkg::ST_HOLD) begin
      if (slot_free) begin
        rsp <= pend;
      end
    end else if (finish) begin
      if (slot_free) begin
        rsp <= fin_rsp;
      end else begin
        pend <= fin_rsp;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_store_two_sum_search.sv =====
// Top level: sequencer plus a chain of STORE_DEPTH storage cells.
// Depends on ssts_pkg, ssts_cell, ssts_ctrl.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   req     | req_valid/req_ready  | ssts_pkg::req_t (action, operand_value)
//   rsp     | rsp_valid/rsp_ready  | ssts_pkg::rsp_t (status, index_low, index_high)
//
// Clear, insert, unused codes and a query on fewer than two entries are
// decided in the cycle they are accepted: the cells shift and compare in
// parallel. A query with n entries loads both search lines, aligns the high
// line at the top cell, and then searches with up to n - 1 pointer steps (one
// 33-bit add and compare each) plus the last compare. Synchronous reset
// empties the store. A result that is not taken holds the next item's
// result in a pending slot, and then req_ready stays low.
`default_nettype none

module sorted_store_two_sum_search #(
  parameter int STORE_DEPTH = ssts_pkg::STORE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ssts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ssts_pkg::rsp_t rsp
);

  ssts_pkg::cmd_t  cmd;
  ssts_pkg::link_t links [STORE_DEPTH];
  ssts_pkg::link_t bottom;
  ssts_pkg::link_t top;

  // below cell 0: always "valid", never greater, empty high line
  always_comb begin
    bottom       = '0;
    bottom.valid = 1'b1;
  end
  assign top = '0;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    ssts_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .dn   ((i == 0) ? bottom : links[(i == 0) ? 0 : i - 1]),
      .up   ((i == STORE_DEPTH - 1) ? top : links[(i == STORE_DEPTH - 1) ? i : i + 1]),
      .self (links[i])
    );
  end

  ssts_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .lo_val    (links[0].l),
    .hi_val    (links[STORE_DEPTH-1].h),
    .hi_hv     (links[STORE_DEPTH-1].hv)
  );

endmodule

`default_nettype wire
